// ----- rtl/rth_pkg.sv -----
// Shared types, constants and the divider step for the RGB to HSV pipeline.
package rth_pkg;

  localparam int CHAN_W = 8;
  localparam int HUE_W = 13;
  localparam int QUOT_W = 10;
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES = QUOT_W / DIV_STEPS_PER_STAGE;
  localparam int LATENCY = DIV_STAGES + 3;

  localparam logic [1:0] SECTOR_RED = 2'd0;
  localparam logic [1:0] SECTOR_GREEN = 2'd1;
  localparam logic [1:0] SECTOR_BLUE = 2'd2;

  localparam logic [HUE_W-1:0] SECTOR_SPAN = 13'd1920;
  localparam logic [HUE_W-1:0] DOUBLE_SPAN = 13'd3840;
  localparam logic [HUE_W-1:0] FULL_TURN = 13'd5760;

  typedef struct packed {
    logic [1:0]        sector;
    logic              neg;
    logic [CHAN_W-1:0] brightness;
    logic              black;
    logic              grey;
  } info_t;

  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [QUOT_W-1:0] num;
    logic [QUOT_W-1:0] quot;
    logic [CHAN_W-1:0] dvsr;
  } div_lane_t;

  function automatic div_lane_t div_step(div_lane_t lane);
    logic [CHAN_W:0] sh;
    logic [CHAN_W:0] dif;
    logic            ge;
    div_lane_t       res;
    sh = {lane.rem, lane.num[QUOT_W-1]};
    dif = sh - {1'b0, lane.dvsr};
    ge = (sh >= {1'b0, lane.dvsr});
    res = lane;
    res.num = {lane.num[QUOT_W-2:0], 1'b0};
    res.rem = ge ? dif[CHAN_W-1:0] : sh[CHAN_W-1:0];
    res.quot = {lane.quot[QUOT_W-2:0], ge};
    return res;
  endfunction

endpackage

// ----- rtl/rgb_to_hsv_converter_top.sv -----
// Top level of the pipelined RGB to HSV hexcone converter.
// Usage:
//   Drive red, green and blue with start high; the pixel transfers at any
//   rising edge where start is high and busy is low. busy is held low, so a
//   new pixel may transfer in every clock cycle.
//   Each result shows on hue, saturation, brightness and hue_undefined for
//   exactly one cycle with done high, and transfers at the edge that ends
//   that cycle. Results come out in the order the pixels went in.
// Pipeline: a pixel passes through two front stages, five divider stages
//   of two quotient bits each, and one output register.
// Throughput: one pixel per cycle, set by the fully pipelined restoring
//   divider that forms both saturation and hue.
// Reset: synchronous rst clears every stage valid bit; pixels in flight
//   are dropped and done stays low until new pixels arrive.
// Stall: the receiver cannot hold results off, so the pipeline never stalls.
module rgb_to_hsv_converter_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [rth_pkg::CHAN_W-1:0]  red,
  input  logic [rth_pkg::CHAN_W-1:0]  green,
  input  logic [rth_pkg::CHAN_W-1:0]  blue,
  output logic                        done,
  output logic [rth_pkg::HUE_W-1:0]   hue,
  output logic [rth_pkg::CHAN_W-1:0]  saturation,
  output logic [rth_pkg::CHAN_W-1:0]  brightness,
  output logic                        hue_undefined
);

  logic                valid [rth_pkg::DIV_STAGES+1];
  rth_pkg::info_t      info  [rth_pkg::DIV_STAGES+1];
  rth_pkg::div_lane_t  sat   [rth_pkg::DIV_STAGES+1];
  rth_pkg::div_lane_t  hl    [rth_pkg::DIV_STAGES+1];

  assign busy = 1'b0;

  rth_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (valid[0]),
    .out_info  (info[0]),
    .out_sat   (sat[0]),
    .out_hue   (hl[0])
  );

  for (genvar s = 0; s < rth_pkg::DIV_STAGES; s++) begin : g_div
    rth_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[s]),
      .in_info   (info[s]),
      .in_sat    (sat[s]),
      .in_hue    (hl[s]),
      .out_valid (valid[s+1]),
      .out_info  (info[s+1]),
      .out_sat   (sat[s+1]),
      .out_hue   (hl[s+1])
    );
  end

  rth_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (valid[rth_pkg::DIV_STAGES]),
    .in_info       (info[rth_pkg::DIV_STAGES]),
    .sat_quot      (sat[rth_pkg::DIV_STAGES].quot),
    .hue_quot      (hl[rth_pkg::DIV_STAGES].quot),
    .done          (done),
    .hue           (hue),
    .saturation    (saturation),
    .brightness    (brightness),
    .hue_undefined (hue_undefined)
  );

`ifndef SYNTH
  a_done_follows_transfer: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, rth_pkg::LATENCY))
    else $error("result without a matching input transfer");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hue < rth_pkg::FULL_TURN))
    else $error("hue out of range");

  a_grey_result: assert property (@(posedge clk) disable iff (rst)
    (done && hue_undefined) |-> ((hue == '0) && (saturation == '0) && (brightness != '0)))
    else $error("grey pixel with nonzero hue or saturation");

  a_black_result: assert property (@(posedge clk) disable iff (rst)
    (done && (brightness == '0)) |-> (!hue_undefined && (saturation == '0) && (hue == '0)))
    else $error("black pixel with nonzero fields");
`endif

endmodule

// ----- rtl/rth_front.sv -----
// Front stages: channel max and min, sector, difference, then divider operands.
module rth_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [rth_pkg::CHAN_W-1:0]   red,
  input  logic [rth_pkg::CHAN_W-1:0]   green,
  input  logic [rth_pkg::CHAN_W-1:0]   blue,
  output logic                         out_valid,
  output rth_pkg::info_t               out_info,
  output rth_pkg::div_lane_t           out_sat,
  output rth_pkg::div_lane_t           out_hue
);

  logic [rth_pkg::CHAN_W-1:0] mx_next;
  logic [rth_pkg::CHAN_W-1:0] mn_next;
  logic [1:0]                 sector_next;
  logic [rth_pkg::CHAN_W:0]   diff_next;
  logic [rth_pkg::CHAN_W-1:0] ad_next;

  logic                       s1_valid;
  logic [rth_pkg::CHAN_W-1:0] s1_mx;
  logic [rth_pkg::CHAN_W-1:0] s1_delta;
  logic [rth_pkg::CHAN_W-1:0] s1_ad;
  logic [1:0]                 s1_sector;
  logic                       s1_neg;

  logic [15:0]                sat_num;
  logic [17:0]                hue_num;

  always_comb begin
    mx_next = red;
    sector_next = rth_pkg::SECTOR_RED;
    if (green > mx_next) begin
      mx_next = green;
      sector_next = rth_pkg::SECTOR_GREEN;
    end
    if (blue > mx_next) begin
      mx_next = blue;
      sector_next = rth_pkg::SECTOR_BLUE;
    end
    mn_next = red;
    if (green < mn_next) mn_next = green;
    if (blue < mn_next) mn_next = blue;
    unique case (sector_next)
      rth_pkg::SECTOR_RED:   diff_next = {1'b0, green} - {1'b0, blue};
      rth_pkg::SECTOR_GREEN: diff_next = {1'b0, blue} - {1'b0, red};
      default:               diff_next = {1'b0, red} - {1'b0, green};
    endcase
    ad_next = diff_next[rth_pkg::CHAN_W] ? rth_pkg::CHAN_W'(-diff_next)
                                         : diff_next[rth_pkg::CHAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_mx <= mx_next;
    s1_delta <= mx_next - mn_next;
    s1_ad <= ad_next;
    s1_sector <= sector_next;
    s1_neg <= diff_next[rth_pkg::CHAN_W];
  end

  assign sat_num = {s1_delta, 8'b0} - {8'b0, s1_delta};
  assign hue_num = {s1_ad, 10'b0} - {4'b0, s1_ad, 6'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
    out_info.sector <= s1_sector;
    out_info.neg <= s1_neg;
    out_info.brightness <= s1_mx;
    out_info.black <= (s1_mx == '0);
    out_info.grey <= (s1_mx != '0) && (s1_delta == '0);
    out_sat.rem <= {2'b0, sat_num[15:10]};
    out_sat.num <= sat_num[9:0];
    out_sat.quot <= '0;
    out_sat.dvsr <= s1_mx;
    out_hue.rem <= hue_num[17:10];
    out_hue.num <= hue_num[9:0];
    out_hue.quot <= '0;
    out_hue.dvsr <= s1_delta;
  end

endmodule

// ----- rtl/rth_div_stage.sv -----
// One divider stage: two quotient bits for both the saturation and the hue lane.
module rth_div_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  rth_pkg::info_t      in_info,
  input  rth_pkg::div_lane_t  in_sat,
  input  rth_pkg::div_lane_t  in_hue,
  output logic                out_valid,
  output rth_pkg::info_t      out_info,
  output rth_pkg::div_lane_t  out_sat,
  output rth_pkg::div_lane_t  out_hue
);

  rth_pkg::div_lane_t sat_next;
  rth_pkg::div_lane_t hue_next;

  always_comb begin
    sat_next = in_sat;
    hue_next = in_hue;
    for (int i = 0; i < rth_pkg::DIV_STEPS_PER_STAGE; i++) begin
      sat_next = rth_pkg::div_step(sat_next);
      hue_next = rth_pkg::div_step(hue_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_info <= in_info;
    out_sat <= sat_next;
    out_hue <= hue_next;
  end

endmodule

// ----- rtl/rth_back.sv -----
// Output stage: sector offset, hue wrap, special cases and the result register.
module rth_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  rth_pkg::info_t              in_info,
  input  logic [rth_pkg::QUOT_W-1:0]  sat_quot,
  input  logic [rth_pkg::QUOT_W-1:0]  hue_quot,
  output logic                        done,
  output logic [rth_pkg::HUE_W-1:0]   hue,
  output logic [rth_pkg::CHAN_W-1:0]  saturation,
  output logic [rth_pkg::CHAN_W-1:0]  brightness,
  output logic                        hue_undefined
);

  logic [rth_pkg::HUE_W-1:0] q;
  logic [rth_pkg::HUE_W-1:0] hue_next;
  logic                      special;

  assign q = {{(rth_pkg::HUE_W-rth_pkg::QUOT_W){1'b0}}, hue_quot};
  assign special = in_info.black || in_info.grey;

  always_comb begin
    unique case (in_info.sector)
      rth_pkg::SECTOR_RED: begin
        if (in_info.neg && (q != '0)) hue_next = rth_pkg::FULL_TURN - q;
        else                          hue_next = q;
      end
      rth_pkg::SECTOR_GREEN: begin
        hue_next = in_info.neg ? rth_pkg::SECTOR_SPAN - q : rth_pkg::SECTOR_SPAN + q;
      end
      rth_pkg::SECTOR_BLUE: begin
        hue_next = in_info.neg ? rth_pkg::DOUBLE_SPAN - q : rth_pkg::DOUBLE_SPAN + q;
      end
      default: hue_next = '0;
    endcase
    if (special) hue_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    hue <= hue_next;
    saturation <= special ? '0 : sat_quot[rth_pkg::CHAN_W-1:0];
    brightness <= in_info.brightness;
    hue_undefined <= in_info.grey;
  end

endmodule
